// ===== rtl/sra_pkg.sv =====
package sra_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int SCORE_W = 32;
  localparam int OFF_W   = 16;
  localparam int IDX_W   = 6;
  localparam int TOTAL_W = 38;
  // Both sides of the slot compare stay below 2^60
  localparam int CMP_W   = 61;
  localparam int FRAC_W  = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_FETCH,
    ST_MUL,
    ST_ADD,
    ST_CMP,
    ST_EMIT
  } sra_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic accum;
    logic advance;
    logic next_slot;
    logic clear;
  } sra_cmd_t;

  typedef struct packed {
    logic can_advance;
    logic final_slot;
  } sra_sts_t;

endpackage

// ===== rtl/systematic_resampler_with_argmax.sv =====
// Systematic resampler with running argmax. Scores (unsigned Q16.16) load one
// per cycle while in_ready is high; each is stored, summed and compared with
// the best so far (later index wins ties). Scores past MAX_PARTICLES are
// dropped. The transaction marked in_last_score starts the walk: in_ready drops
// and one result per loaded particle follows, with the surviving index, best
// index and best score, and out_last_sample on the final one. Each move of the
// walk index passes through the fetch, multiply, add and compare states, paced
// by the registered read of the score store and the scaled-score multiplier;
// each result is held until out_ready takes it. A batch whose scores sum to
// zero reports zero_total with all indices 0. Loading resumes once the final
// result is taken.
module systematic_resampler_with_argmax #(
  parameter int MAX_PARTICLES = sra_pkg::MAX_PARTICLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sra_pkg::SCORE_W-1:0] in_score,
  input  logic [sra_pkg::OFF_W-1:0]   in_slot_offset,
  input  logic                        in_last_score,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sra_pkg::IDX_W-1:0]   out_sample_index,
  output logic [sra_pkg::IDX_W-1:0]   out_best_index,
  output logic [sra_pkg::SCORE_W-1:0] out_best_score,
  output logic                        out_zero_total,
  output logic                        out_last_sample
);

  import sra_pkg::*;

  sra_cmd_t cmd;
  sra_sts_t sts;

  sra_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_score (in_last_score),
    .out_ready     (out_ready),
    .sts           (sts),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  sra_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_score         (in_score),
    .in_slot_offset   (in_slot_offset),
    .in_last_score    (in_last_score),
    .sts              (sts),
    .out_sample_index (out_sample_index),
    .out_best_index   (out_best_index),
    .out_best_score   (out_best_score),
    .out_zero_total   (out_zero_total),
    .out_last_sample  (out_last_sample)
  );

`ifndef NO_ASSERTIONS
  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_score) |=> !in_ready)
    else $error("loading continued after the last score");

  a_final_resumes_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_sample) |=> (in_ready && !out_valid))
    else $error("loading did not resume after the final result");

  a_zero_indices: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_total) |->
      (out_sample_index == '0 && out_best_index == '0))
    else $error("nonzero index on a zero-total batch");
`endif

endmodule

// ===== rtl/sra_ram.sv =====
module sra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sra_ctrl.sv =====
module sra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_score,
  input  logic              out_ready,
  input  sra_pkg::sra_sts_t sts,
  output logic              in_ready,
  output logic              out_valid,
  output sra_pkg::sra_cmd_t cmd
);

  import sra_pkg::*;

  sra_state_t state_r;
  sra_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_score) begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (sts.can_advance) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          state_nxt = sts.final_slot ? ST_LOAD : ST_CMP;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_START: cmd.start = 1'b1;
      ST_FETCH: ;
      ST_MUL:   ;
      ST_ADD:   cmd.accum = 1'b1;
      ST_CMP:   cmd.advance = sts.can_advance;
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.next_slot = out_ready && !sts.final_slot;
        cmd.clear     = out_ready && sts.final_slot;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sra_dp.sv =====
module sra_dp #(
  parameter int MAX_PARTICLES = sra_pkg::MAX_PARTICLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sra_pkg::sra_cmd_t           cmd,
  input  logic [sra_pkg::SCORE_W-1:0] in_score,
  input  logic [sra_pkg::OFF_W-1:0]   in_slot_offset,
  input  logic                        in_last_score,
  output sra_pkg::sra_sts_t           sts,
  output logic [sra_pkg::IDX_W-1:0]   out_sample_index,
  output logic [sra_pkg::IDX_W-1:0]   out_best_index,
  output logic [sra_pkg::SCORE_W-1:0] out_best_score,
  output logic                        out_zero_total,
  output logic                        out_last_sample
);

  import sra_pkg::*;

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int PW = SCORE_W + CW;
  localparam int SW = OFF_W + TOTAL_W;

  logic [CW-1:0]      count_r;
  logic [TOTAL_W-1:0] total_r;
  logic [SCORE_W-1:0] top_score_r;
  logic [IW-1:0]      top_idx_r;
  logic [OFF_W-1:0]   off_r;
  logic [CMP_W-1:0]   lhs_r;
  logic [CMP_W-1:0]   rhs_r;
  logic [PW-1:0]      prod_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      slot_r;

  logic [SCORE_W-1:0] rdata;
  logic [PW-1:0]      scaled;
  logic [SW-1:0]      start_prod;
  logic               full;
  logic               store_en;
  logic               zero;

  assign full     = (count_r == CW'(MAX_PARTICLES));
  assign store_en = cmd.load && !full;
  assign zero     = (total_r == '0);
  assign scaled     = rdata * count_r;
  assign start_prod = off_r * total_r;

  sra_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (count_r[IW-1:0]),
    .wdata (in_score),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // Batch accumulators: loaded on each score, cleared after the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      top_score_r <= '0;
      top_idx_r   <= '0;
    end else if (cmd.clear) begin
      count_r     <= '0;
      total_r     <= '0;
      top_score_r <= '0;
      top_idx_r   <= '0;
    end else if (store_en) begin
      count_r <= count_r + CW'(1);
      total_r <= total_r + TOTAL_W'(in_score);
      if (in_score >= top_score_r) begin
        top_score_r <= in_score;
        top_idx_r   <= count_r[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= scaled;
    if (cmd.load && in_last_score) begin
      off_r <= in_slot_offset;
    end
    if (cmd.start) begin
      lhs_r  <= CMP_W'(start_prod);
      rhs_r  <= '0;
      idx_r  <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.accum) begin
        rhs_r <= rhs_r + (CMP_W'(prod_r) << FRAC_W);
      end
      if (cmd.advance) begin
        idx_r <= idx_r + IW'(1);
      end
      // Advance one slot: lhs grows by total scaled to one full slot
      if (cmd.next_slot) begin
        lhs_r  <= lhs_r + (CMP_W'(total_r) << FRAC_W);
        slot_r <= slot_r + IW'(1);
      end
    end
  end

  assign sts.can_advance = !zero && (lhs_r > rhs_r) && ((CW'(idx_r) + CW'(1)) < count_r);
  assign sts.final_slot  = ((CW'(slot_r) + CW'(1)) == count_r);

  assign out_sample_index = IDX_W'(idx_r);
  assign out_best_index   = zero ? '0 : IDX_W'(top_idx_r);
  assign out_best_score   = zero ? '0 : top_score_r;
  assign out_zero_total   = zero;
  assign out_last_sample  = sts.final_slot;

endmodule

// ===== test/systematic_resampler_with_argmax_test.sv =====
module systematic_resampler_with_argmax_test;
  import sra_pkg::*;

  localparam int SLOTS = MAX_PARTICLES_DEF;

  typedef struct {
    logic [IDX_W-1:0]   sample_index;
    logic [IDX_W-1:0]   best_index;
    logic [SCORE_W-1:0] best_score;
    logic               zero_total;
    logic               last_sample;
  } sample_t;

  class resample_board;
    logic [SCORE_W-1:0] scores[SLOTS];
    int unsigned        loaded;
    logic [TOTAL_W-1:0] total;
    logic [SCORE_W-1:0] top_score;
    logic [IDX_W-1:0]   top_index;
    sample_t            pending_samples[$];
    int                 mismatches;
    int                 samples_taken;

    function new();
      foreach (scores[k]) scores[k] = '0;
      loaded = 0;
      total = '0;
      top_score = '0;
      top_index = '0;
      mismatches = 0;
      samples_taken = 0;
    endfunction

    // Load one score; on the last one walk the batch and queue one sample per particle.
    function void load_score(logic [SCORE_W-1:0] s, logic [OFF_W-1:0] off, logic last);
      int unsigned        m;
      int unsigned        idx;
      logic [63:0]        cum;
      logic [63:0]        lhs;
      logic [63:0]        rhs_scale;
      logic               zero;
      sample_t            smp;
      if (loaded < SLOTS) begin
        scores[loaded] = s;
        total = total + TOTAL_W'(s);
        if (s >= top_score) begin
          top_score = s;
          top_index = IDX_W'(loaded);
        end
        loaded++;
      end
      if (!last) return;
      m = loaded;
      zero = (total == '0);
      idx = 0;
      cum = 64'(scores[0]);
      rhs_scale = 64'(m) << FRAC_W;
      for (int unsigned i = 0; i < m; i++) begin
        smp.sample_index = '0;
        if (!zero) begin
          lhs = (64'(off) + (64'(i) << FRAC_W)) * 64'(total);
          // advance the walk, never past the last loaded particle
          while (idx + 1 < m && lhs > cum * rhs_scale) begin
            idx++;
            cum = cum + 64'(scores[idx]);
          end
          smp.sample_index = IDX_W'(idx);
        end
        smp.best_index  = zero ? '0 : top_index;
        smp.best_score  = zero ? '0 : top_score;
        smp.zero_total  = zero;
        smp.last_sample = (i + 1 == m);
        pending_samples = {pending_samples, smp};
      end
      loaded = 0;
      total = '0;
      top_score = '0;
      top_index = '0;
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      samples_taken++;
      if (pending_samples.size() == 0) begin
        $error("unexpected result transaction: sample_index %0d", got.sample_index);
        mismatches++;
        return;
      end
      want = pending_samples.pop_front();
      if (got.sample_index !== want.sample_index) begin
        $error("sample_index: expected %0d, got %0d", want.sample_index, got.sample_index);
        mismatches++;
      end
      if (got.best_index !== want.best_index) begin
        $error("best_index: expected %0d, got %0d", want.best_index, got.best_index);
        mismatches++;
      end
      if (got.best_score !== want.best_score) begin
        $error("best_score: expected %0h, got %0h", want.best_score, got.best_score);
        mismatches++;
      end
      if (got.zero_total !== want.zero_total) begin
        $error("zero_total: expected %0b, got %0b", want.zero_total, got.zero_total);
        mismatches++;
      end
      if (got.last_sample !== want.last_sample) begin
        $error("last_sample: expected %0b, got %0b", want.last_sample, got.last_sample);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [SCORE_W-1:0] in_score;
  logic [OFF_W-1:0]   in_slot_offset;
  logic               in_last_score;
  logic               out_valid;
  logic               out_ready;
  logic [IDX_W-1:0]   out_sample_index;
  logic [IDX_W-1:0]   out_best_index;
  logic [SCORE_W-1:0] out_best_score;
  logic               out_zero_total;
  logic               out_last_sample;

  resample_board board;
  int                items_sent;
  bit                calm;
  bit                held_off;

  systematic_resampler_with_argmax DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_score         (in_score),
    .in_slot_offset   (in_slot_offset),
    .in_last_score    (in_last_score),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_index (out_sample_index),
    .out_best_index   (out_best_index),
    .out_best_score   (out_best_score),
    .out_zero_total   (out_zero_total),
    .out_last_sample  (out_last_sample)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Record accepted scores and check accepted samples at the rising edge.
  always @(posedge clk) begin
    sample_t got;
    if (rst_n) begin
      if (in_valid && in_ready) board.load_score(in_score, in_slot_offset, in_last_score);
      if (out_valid && out_ready) begin
        got.sample_index = out_sample_index;
        got.best_index   = out_best_index;
        got.best_score   = out_best_score;
        got.zero_total   = out_zero_total;
        got.last_sample  = out_last_sample;
        board.check_sample(got);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back up the input.
  initial begin
    out_ready = 1'b0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && !held_off && board != null && board.samples_taken >= 30) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_score(input logic [SCORE_W-1:0] s, input logic [OFF_W-1:0] off,
                            input logic last);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_score       <= s;
    in_slot_offset <= off;
    in_last_score  <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
  endtask

  function automatic logic [SCORE_W-1:0] pick_score(int mode);
    case (mode)
      1:       return SCORE_W'($urandom_range(0, 3));
      2:       return '0;
      3: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return SCORE_W'($urandom);
        endcase
      end
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int n, input int mode);
    for (int k = 0; k < n; k++)
      send_score(pick_score(mode), OFF_W'($urandom), k == n - 1);
  endtask

  initial begin
    int n;
    board = new();
    items_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_score = '0;
    in_slot_offset = '0;
    in_last_score = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extreme scores, tie goes to the later index, largest offset
    send_score('1, 16'h0000, 1'b0);
    send_score('0, 16'h0000, 1'b0);
    send_score('1, 16'hFFFF, 1'b1);
    // zero total, single particle and several
    send_score('0, 16'h0000, 1'b1);
    repeat (3) send_score('0, 16'h5A5A, 1'b0);
    send_score('0, 16'h1234, 1'b1);
    // walk skips a run of zero scores
    send_score(32'd1, 16'h0000, 1'b0);
    repeat (5) send_score('0, 16'hFFFF, 1'b0);
    send_score(32'd1, 16'h0000, 1'b1);
    // leading zeros, weight only on the last particle
    repeat (3) send_score('0, 16'h0000, 1'b0);
    send_score(32'h0005_0000, 16'hFFFF, 1'b1);
    // equal scores
    send_score(32'd7, 16'h0000, 1'b0);
    send_score(32'd7, 16'h8000, 1'b1);

    // fill or overfill the store first, then mostly small batches
    send_batch($urandom_range(64, 68), 0);
    while (items_sent < 160) begin
      if (items_sent > 130) calm = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
      // trim the last batch so the run ends at 160 scores
      if (n > 160 - items_sent) n = 160 - items_sent;
      send_batch(n, $urandom_range(0, 3));
    end
    calm = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== systematic_resampler_with_argmax.f =====
rtl/sra_pkg.sv
rtl/sra_ram.sv
rtl/sra_ctrl.sv
rtl/sra_dp.sv
rtl/systematic_resampler_with_argmax.sv
test/systematic_resampler_with_argmax_test.sv
